// ===== hdl/sorted_list_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sorted list queue assertion macros
// shared property wrappers for the sorted list queue checks
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_QUEUE_UNIT_ASSERT_SVH
`define SORTED_LIST_QUEUE_UNIT_ASSERT_SVH

// check outside reset
`define SLQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted list queue check failed");

// check that also holds across reset
`define SLQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted list queue reset check failed");

`endif

// ===== hdl/slq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slq_pkg
// types and constants shared by the sorted list queue modules
// ----------------------------------------------------------------------------
package slq_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT       = 2'd0,
    MODE_REMOVE_FRONT = 2'd1,
    MODE_REMOVE_MATCH = 2'd2,
    MODE_FIND         = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  // stored key, vertex above weight so a plain compare gives the sort order
  typedef struct packed {
    logic [7:0]  vertex;
    logic [15:0] weight;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_vertex;
    logic [15:0] key_weight;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        front_valid;
    logic [7:0]  front_vertex;
    logic [15:0] front_weight;
    logic [4:0]  occupancy;
  } res_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove_front;
    logic remove_match;
  } cell_ctrl_t;

endpackage

// ===== hdl/slq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slq_cell
// one slot of the sorted chain: compares against the broadcast key and
// takes its next entry from itself, the key or a neighbor
// ----------------------------------------------------------------------------
module slq_cell (
  input  logic               clk,
  input  slq_pkg::cell_ctrl_t ctrl,
  input  slq_pkg::entry_t    key,
  input  logic               occupied,
  input  logic               left_lt,
  input  slq_pkg::entry_t    left_entry,
  input  slq_pkg::entry_t    right_entry,
  output logic               lt,
  output logic               match,
  output slq_pkg::entry_t    entry,
  output slq_pkg::entry_t    entry_next
);
  import slq_pkg::*;

  logic eq;

  assign lt    = occupied && (entry < key);
  assign eq    = occupied && (entry == key);
  // first equal entry sits right after the last smaller one
  assign match = eq && left_lt;

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!lt) begin
        entry_next = left_lt ? key : left_entry;
      end
    end else if (ctrl.remove_front || (ctrl.remove_match && !lt)) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/sorted_list_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_queue_unit
// bounded ascending list of (vertex, weight) keys held in a chain of cells
// ----------------------------------------------------------------------------
// usage
//   op channel (op_valid / op_ready / op): one operation per transfer, mode
//   0 insert, 1 remove front, 2 remove first matching key, 3 find key
//   res channel (res_valid / res_ready / res): one result per operation with
//   status, the front entry and the occupancy after the operation
//   result: registered, valid in the cycle after the op transfer
//   throughput: one operation per cycle unless stalled; every cell compares
//   its entry with the broadcast key and loads its new entry in the same
//   cycle, so the row compare plus the found reduction sets the cycle
//   stall: the result register holds while res_ready is low, and op_ready
//   drops until that result is taken
//   reset: clears the entry count and the result valid; cell contents are
//   left as they are and only cells below the count are ever looked at
//   capacity LIST_DEPTH entries; an insert into a full list is dropped with
//   status full
// ----------------------------------------------------------------------------
module sorted_list_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  slq_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_ready,
  output slq_pkg::res_t res
);
  import slq_pkg::*;

  // occupancy
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // cell row wiring
  entry_t                key;
  cell_ctrl_t            ctrl;
  logic [LIST_DEPTH-1:0] occ;
  logic [LIST_DEPTH-1:0] lt;
  logic [LIST_DEPTH-1:0] match;
  entry_t                entries     [LIST_DEPTH];
  entry_t                entries_next[LIST_DEPTH];

  logic    accept;
  logic    full;
  logic    empty;
  logic    found;
  status_t status;
  res_t    res_next;

  assign key    = '{vertex: op.key_vertex, weight: op.key_weight};
  assign accept = op_valid && op_ready;
  // output register frees up as soon as its result transfers
  assign op_ready = !res_valid || res_ready;

  assign full  = (count == CNT_W'(LIST_DEPTH));
  assign empty = (count == '0);
  assign found = |match;

  // cell row, left neighbor is the smaller side
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic   left_lt;
    entry_t left_entry;
    entry_t right_entry;

    assign occ[g] = (CNT_W'(g) < count);

    if (g == 0) begin : g_head
      // head cell: nothing smaller to its left
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lt    = lt[g-1];
      assign left_entry = entries[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[g+1];
    end

    slq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .occupied    (occ[g]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .lt          (lt[g]),
      .match       (match[g]),
      .entry       (entries[g]),
      .entry_next  (entries_next[g])
    );
  end

  // operation decode
  always_comb begin
    ctrl       = '0;
    status     = STATUS_OK;
    count_next = count;
    unique case (op.mode)
      MODE_INSERT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          ctrl.insert = accept;
          count_next  = count + 1'b1;
        end
      end
      MODE_REMOVE_FRONT: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          ctrl.remove_front = accept;
          count_next        = count - 1'b1;
        end
      end
      MODE_REMOVE_MATCH: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else if (!found) begin
          status = STATUS_NOT_FOUND;
        end else begin
          ctrl.remove_match = accept;
          count_next        = count - 1'b1;
        end
      end
      MODE_FIND: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else if (!found) begin
          status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  // result as seen after the update, front taken from the head cell
  always_comb begin
    res_next.status      = status;
    res_next.front_valid = (count_next != '0);
    res_next.front_vertex = res_next.front_valid ? entries_next[0].vertex : 8'd0;
    res_next.front_weight = res_next.front_valid ? entries_next[0].weight : 16'd0;
    res_next.occupancy    = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (op_ready) begin
        res_valid <= op_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/slq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slq_checker
// port-level checks on the sorted list queue, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_list_queue_unit_assert.svh"

module slq_checker (
  input logic          clk,
  input logic          rst,
  input logic          op_ready,
  input logic          res_valid,
  input logic          res_ready,
  input slq_pkg::res_t res
);
  import slq_pkg::*;

  // no result pending right after reset
  `SLQ_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !res_valid)

  // stalled result holds
  `SLQ_ASSERT(a_result_holds, res_valid && !res_ready |=> res_valid && $stable(res))

  // empty list reports a zero front
  `SLQ_ASSERT(a_empty_front_zero,
    res_valid && !res.front_valid |-> res.front_vertex == 8'd0 && res.front_weight == 16'd0)

  // an empty status leaves nothing in the list
  `SLQ_ASSERT(a_empty_status,
    res_valid && res.status == STATUS_EMPTY |-> !res.front_valid && res.occupancy == 5'd0)

  // a new operation is taken only when no result is pending or the pending result leaves
  `SLQ_ASSERT(a_ready_follows_result, op_ready == (!res_valid || res_ready))

endmodule

bind sorted_list_queue_unit slq_checker u_slq_checker (
  .clk       (clk),
  .rst       (rst),
  .op_ready  (op_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
